[rtl/opi_pkg.sv]
// shared widths, constants and tables of the odometry pose integrator
package opi_pkg;

    // stream payload layout
    localparam int POS_W      = 32;
    localparam int HEAD_W     = 17;
    localparam int NEW_HEAD_W = 16;
    localparam int SPEED_W    = 16;
    localparam int DT_W       = 20;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 88;

    // cordic: angles in q2.30, reduction word wide enough for heading * 2^18
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_STEPS_MAX = 24;
    localparam int ATAN_IDX_W       = 5;
    localparam int ANG_W            = 36;
    localparam int ROT_W            = 34;
    localparam int ANG_LSB_PAD      = 18;

    localparam logic signed [ANG_W-1:0] ANG_PI           = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] ANG_NEG_PI       = -36'sd3373259426;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI      = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] ANG_NEG_HALF_PI  = -36'sd1686629713;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI       = 36'sd6746518852;
    localparam logic signed [ROT_W-1:0] CORDIC_GAIN      = 34'sd652032874;
    localparam int                      REDUCE_PASSES    = 4;

    localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS_MAX] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127
    };

    // serial multiplier: magnitude times magnitude
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 20;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // speed times cos/sin, q8.8 * q1.30 -> q9.16 by a rounded shift
    localparam int VEL_W     = 25;
    localparam int VEL_SHIFT = 22;

    // serial rounded divider by one million
    localparam int          DIV_N_W  = 45;
    localparam int          DIV_Q_W  = 25;
    localparam int          DIV_R_W  = 20;
    localparam logic [DIV_R_W-1:0] US_PER_S = 20'd1000000;
    localparam logic [DIV_R_W-1:0] US_HALF  = 20'd500000;

    // heading wrap, q4.12
    localparam int                 TH_W       = 19;
    localparam logic signed [TH_W-1:0] WRAP_LIMIT     = 19'sd25763;
    localparam logic signed [TH_W-1:0] WRAP_NEG_LIMIT = -19'sd25763;
    localparam logic signed [TH_W-1:0] WRAP_STEP      = 19'sd25736;
    localparam logic signed [TH_W-1:0] HEAD_MAX       = 19'sd65535;
    localparam logic signed [TH_W-1:0] HEAD_MIN       = -19'sd65536;

endpackage

[rtl/odometry_pose_integrator_top.sv]
// odometry pose integrator: dead reckoning of x, y and heading per tick
//
// input stream (s_*): one transfer per tick. s_tuser is the load flag; when set
// the pose in s_tdata is taken as is, otherwise speed and turn rate are
// integrated over elapsed_us. output stream (m_*): one transfer per tick with
// the pose after that tick.
// a tick that integrates runs a cordic (4 reduction passes, 1 fold, one
// micro-rotation per cycle), then two serial multiplies and a serial divide
// by one million, the x, y and heading lanes side by side, then the pose
// update and the output state; a load or a tick with both speeds zero goes
// straight to the output state. one tick is in work at a time and s_tready
// rises together with m_tvalid, so a new tick is taken only once the last
// one has reached the output register; the serial multiplier and divider
// take the bulk of a tick's time.
// s_tready is high whenever no tick is in work, also while a result waits in
// the output register. when the receiver stalls, the result holds in m_tdata
// and a finished tick behind it waits until the output register frees.
// reset (aresetn low, synchronous) clears the pose to zero and drops m_tvalid.
module odometry_pose_integrator_top
    import opi_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // new_x, new_y, new_heading, linear_speed, angular_speed, elapsed_us, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // load_pose
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pos_x, pos_y, heading, zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SINCOS = 7'b0000010,
        ST_MUL_V  = 7'b0000100,
        ST_MUL_DT = 7'b0001000,
        ST_DIV    = 7'b0010000,
        ST_UPDATE = 7'b0100000,
        ST_OUTPUT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic signed [POS_W-1:0]   x_reg;
    logic signed [POS_W-1:0]   y_reg;
    logic signed [HEAD_W-1:0]  head_reg;
    logic signed [SPEED_W-1:0] v_reg;
    logic signed [SPEED_W-1:0] w_reg;
    logic [DT_W-1:0]           dt_reg;
    logic                      sx_reg;
    logic                      sy_reg;
    logic                      m_tvalid_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;

    // input unpack
    logic signed [POS_W-1:0]      in_x;
    logic signed [POS_W-1:0]      in_y;
    logic signed [NEW_HEAD_W-1:0] in_head;
    logic signed [SPEED_W-1:0]    in_v;
    logic signed [SPEED_W-1:0]    in_w;
    logic [DT_W-1:0]              in_dt;

    assign in_x    = s_tdata[31:0];
    assign in_y    = s_tdata[63:32];
    assign in_head = s_tdata[79:64];
    assign in_v    = s_tdata[95:80];
    assign in_w    = s_tdata[111:96];
    assign in_dt   = s_tdata[131:112];

    logic in_xfer;
    logic in_moves;
    logic out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign in_moves = (in_v != '0) || (in_w != '0);
    assign out_free = !m_tvalid_reg || m_tready;

    // cordic
    logic                    cordic_start;
    logic                    cordic_done;
    logic signed [ROT_W-1:0] cos_val;
    logic signed [ROT_W-1:0] sin_val;

    assign cordic_start = in_xfer && !s_tuser[0] && in_moves;

    opi_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   (head_reg),
        .done    (cordic_done),
        .cos_out (cos_val),
        .sin_out (sin_val)
    );

    logic [ROT_W-1:0]   cos_abs;
    logic [ROT_W-1:0]   sin_abs;
    logic [SPEED_W-1:0] v_mag;
    logic [SPEED_W-1:0] w_mag;

    assign cos_abs = cos_val[ROT_W-1] ? -cos_val : cos_val;
    assign sin_abs = sin_val[ROT_W-1] ? -sin_val : sin_val;
    assign v_mag   = v_reg[SPEED_W-1] ? -v_reg : v_reg;
    assign w_mag   = w_reg[SPEED_W-1] ? -w_reg : w_reg;

    // multiplier lanes
    logic               mul_xy_start;
    logic               mul_h_start;
    logic               mul_x_done;
    logic               mul_y_done;
    logic               mul_h_done;
    logic [MUL_A_W-1:0] mcand_x;
    logic [MUL_A_W-1:0] mcand_y;
    logic [MUL_B_W-1:0] mplier_xy;
    logic [MUL_P_W-1:0] prod_x;
    logic [MUL_P_W-1:0] prod_y;
    logic [MUL_P_W-1:0] prod_h;
    logic [MUL_P_W-1:0] rnd_x;
    logic [MUL_P_W-1:0] rnd_y;
    logic [VEL_W-1:0]   vx_mag;
    logic [VEL_W-1:0]   vy_mag;

    // speed times cos/sin, rounded back to q9.16 m/s
    assign rnd_x  = prod_x + (MUL_P_W'(1) << (VEL_SHIFT - 1));
    assign rnd_y  = prod_y + (MUL_P_W'(1) << (VEL_SHIFT - 1));
    assign vx_mag = rnd_x[VEL_SHIFT+VEL_W-1:VEL_SHIFT];
    assign vy_mag = rnd_y[VEL_SHIFT+VEL_W-1:VEL_SHIFT];

    assign mul_xy_start = (state_reg == ST_SINCOS && cordic_done)
                       || (state_reg == ST_MUL_V && mul_x_done && mul_y_done && mul_h_done);
    assign mul_h_start  = (state_reg == ST_SINCOS && cordic_done);

    always_comb begin
        if (state_reg == ST_SINCOS) begin
            mcand_x   = cos_abs[MUL_A_W-1:0];
            mcand_y   = sin_abs[MUL_A_W-1:0];
            mplier_xy = MUL_B_W'(v_mag);
        end else begin
            mcand_x   = MUL_A_W'(vx_mag);
            mcand_y   = MUL_A_W'(vy_mag);
            mplier_xy = dt_reg;
        end
    end

    opi_mul_serial u_mul_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_xy_start),
        .mcand   (mcand_x),
        .mplier  (mplier_xy),
        .done    (mul_x_done),
        .product (prod_x)
    );

    opi_mul_serial u_mul_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_xy_start),
        .mcand   (mcand_y),
        .mplier  (mplier_xy),
        .done    (mul_y_done),
        .product (prod_y)
    );

    opi_mul_serial u_mul_h (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_h_start),
        .mcand   (MUL_A_W'(w_mag)),
        .mplier  (dt_reg),
        .done    (mul_h_done),
        .product (prod_h)
    );

    // divider lanes
    logic               div_start;
    logic               div_x_done;
    logic               div_y_done;
    logic               div_h_done;
    logic [DIV_Q_W-1:0] q_x;
    logic [DIV_Q_W-1:0] q_y;
    logic [DIV_Q_W-1:0] q_h;

    assign div_start = (state_reg == ST_MUL_DT) && mul_x_done && mul_y_done;

    opi_div_serial u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag     (prod_x[DIV_N_W-1:0]),
        .done    (div_x_done),
        .quot    (q_x)
    );

    opi_div_serial u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag     (prod_y[DIV_N_W-1:0]),
        .done    (div_y_done),
        .quot    (q_y)
    );

    opi_div_serial u_div_h (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag     (prod_h[DIV_N_W-1:0]),
        .done    (div_h_done),
        .quot    (q_h)
    );

    // pose update
    logic signed [POS_W+1:0] dx;
    logic signed [POS_W+1:0] dy;
    logic signed [POS_W+1:0] x_sum;
    logic signed [POS_W+1:0] y_sum;
    logic signed [POS_W-1:0] x_next;
    logic signed [POS_W-1:0] y_next;
    logic signed [TH_W-1:0]  dth;
    logic signed [TH_W-1:0]  th_sum;
    logic signed [TH_W-1:0]  th_wrap;
    logic signed [HEAD_W-1:0] head_next;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] val);
        logic signed [POS_W+1:0] hi;
        logic signed [POS_W+1:0] lo;
        hi = (POS_W+2)'({1'b0, {(POS_W-1){1'b1}}});
        lo = -hi - (POS_W+2)'(1);
        if (val > hi) begin
            sat_pos = {1'b0, {(POS_W-1){1'b1}}};
        end else if (val < lo) begin
            sat_pos = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            sat_pos = val[POS_W-1:0];
        end
    endfunction

    assign dx    = sx_reg ? -(POS_W+2)'(q_x) : (POS_W+2)'(q_x);
    assign dy    = sy_reg ? -(POS_W+2)'(q_y) : (POS_W+2)'(q_y);
    assign x_sum = (POS_W+2)'(x_reg) + dx;
    assign y_sum = (POS_W+2)'(y_reg) + dy;
    assign x_next = sat_pos(x_sum);
    assign y_next = sat_pos(y_sum);

    assign dth    = w_reg[SPEED_W-1] ? -{1'b0, q_h[TH_W-2:0]} : {1'b0, q_h[TH_W-2:0]};
    assign th_sum = TH_W'(head_reg) + dth;

    // single wrap by one turn, then clamp to the heading field
    always_comb begin
        if (th_sum > WRAP_LIMIT) begin
            th_wrap = th_sum - WRAP_STEP;
        end else if (th_sum < WRAP_NEG_LIMIT) begin
            th_wrap = th_sum + WRAP_STEP;
        end else begin
            th_wrap = th_sum;
        end
        if (th_wrap > HEAD_MAX) begin
            head_next = HEAD_MAX[HEAD_W-1:0];
        end else if (th_wrap < HEAD_MIN) begin
            head_next = HEAD_MIN[HEAD_W-1:0];
        end else begin
            head_next = th_wrap[HEAD_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = cordic_start ? ST_SINCOS : ST_OUTPUT;
                end
            end
            ST_SINCOS: begin
                if (cordic_done) begin
                    state_next = ST_MUL_V;
                end
            end
            ST_MUL_V: begin
                if (mul_x_done && mul_y_done && mul_h_done) begin
                    state_next = ST_MUL_DT;
                end
            end
            ST_MUL_DT: begin
                if (div_start) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_x_done && div_y_done && div_h_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            x_reg        <= '0;
            y_reg        <= '0;
            head_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (in_xfer && s_tuser[0]) begin
                x_reg    <= in_x;
                y_reg    <= in_y;
                head_reg <= HEAD_W'(in_head);
            end else if (state_reg == ST_UPDATE) begin
                x_reg    <= x_next;
                y_reg    <= y_next;
                head_reg <= head_next;
            end
            if (state_reg == ST_OUTPUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            v_reg  <= in_v;
            w_reg  <= in_w;
            dt_reg <= in_dt;
        end
        // signs of v*cos and v*sin carry through both rounded steps
        if (state_reg == ST_SINCOS && cordic_done) begin
            sx_reg <= v_reg[SPEED_W-1] ^ cos_val[ROT_W-1];
            sy_reg <= v_reg[SPEED_W-1] ^ sin_val[ROT_W-1];
        end
        if (state_reg == ST_OUTPUT && out_free) begin
            m_tdata_reg <= {{(M_TDATA_W-2*POS_W-HEAD_W){1'b0}}, head_reg, y_reg, x_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[rtl/opi_cordic.sv]
// rotation-mode cordic: heading reduction and one micro-rotation per cycle
module opi_cordic
    import opi_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [HEAD_W-1:0] angle,
    output logic                     done,
    output logic signed [ROT_W-1:0]  cos_out,
    output logic signed [ROT_W-1:0]  sin_out
);

    localparam int IT_W = $clog2(STEPS);

    typedef enum logic [3:0] {
        C_IDLE   = 4'b0001,
        C_REDUCE = 4'b0010,
        C_FOLD   = 4'b0100,
        C_ROTATE = 4'b1000
    } cstate_t;

    cstate_t                  state_reg;
    logic signed [ANG_W-1:0]  a_reg;
    logic [1:0]               red_cnt_reg;
    logic [IT_W-1:0]          it_reg;
    logic signed [ROT_W-1:0]  x_reg;
    logic signed [ROT_W-1:0]  y_reg;
    logic signed [ROT_W-1:0]  z_reg;
    logic                     flip_reg;
    logic                     done_reg;
    logic signed [ROT_W-1:0]  cos_reg;
    logic signed [ROT_W-1:0]  sin_reg;

    logic signed [ANG_W-1:0]  a_red;
    logic signed [ANG_W-1:0]  a_fold;
    logic                     fold_flip;
    logic [ATAN_IDX_W-1:0]    atan_idx;
    logic signed [ROT_W-1:0]  atan_val;
    logic signed [ROT_W-1:0]  xs;
    logic signed [ROT_W-1:0]  ys;
    logic signed [ROT_W-1:0]  x_next;
    logic signed [ROT_W-1:0]  y_next;
    logic signed [ROT_W-1:0]  z_next;

    always_comb begin
        if (a_reg > ANG_PI) begin
            a_red = a_reg - ANG_TWO_PI;
        end else if (a_reg <= ANG_NEG_PI) begin
            a_red = a_reg + ANG_TWO_PI;
        end else begin
            a_red = a_reg;
        end
    end

    // fold into the right half plane, negating both outputs
    always_comb begin
        if (a_reg > ANG_HALF_PI) begin
            a_fold    = a_reg - ANG_PI;
            fold_flip = 1'b1;
        end else if (a_reg < ANG_NEG_HALF_PI) begin
            a_fold    = a_reg + ANG_PI;
            fold_flip = 1'b1;
        end else begin
            a_fold    = a_reg;
            fold_flip = 1'b0;
        end
    end

    assign atan_idx = ATAN_IDX_W'(it_reg);
    assign atan_val = signed'(ROT_W'(ATAN_Q30[atan_idx]));
    assign xs       = x_reg >>> it_reg;
    assign ys       = y_reg >>> it_reg;

    always_comb begin
        if (!z_reg[ROT_W-1]) begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_val;
        end else begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE: begin
                    if (start) begin
                        state_reg <= C_REDUCE;
                    end
                end
                C_REDUCE: begin
                    if (red_cnt_reg == 2'(REDUCE_PASSES - 1)) begin
                        state_reg <= C_FOLD;
                    end
                end
                C_FOLD: begin
                    state_reg <= C_ROTATE;
                end
                C_ROTATE: begin
                    if (it_reg == IT_W'(STEPS - 1)) begin
                        state_reg <= C_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            C_IDLE: begin
                a_reg       <= {angle[HEAD_W-1], angle, {ANG_LSB_PAD{1'b0}}};
                red_cnt_reg <= '0;
            end
            C_REDUCE: begin
                a_reg       <= a_red;
                red_cnt_reg <= red_cnt_reg + 2'd1;
            end
            C_FOLD: begin
                z_reg    <= a_fold[ROT_W-1:0];
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
                flip_reg <= fold_flip;
                it_reg   <= '0;
            end
            C_ROTATE: begin
                x_reg  <= x_next;
                y_reg  <= y_next;
                z_reg  <= z_next;
                it_reg <= it_reg + IT_W'(1);
                if (it_reg == IT_W'(STEPS - 1)) begin
                    cos_reg <= flip_reg ? -x_next : x_next;
                    sin_reg <= flip_reg ? -y_next : y_next;
                end
            end
            default: begin
                a_reg <= a_reg;
            end
        endcase
    end

    assign done    = done_reg;
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

[rtl/opi_mul_serial.sv]
// shift-add multiplier, one multiplier bit per cycle, unsigned magnitudes
module opi_mul_serial
    import opi_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [MUL_A_W-1:0] mcand,
    input  logic [MUL_B_W-1:0] mplier,
    output logic               done,
    output logic [MUL_P_W-1:0] product
);

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [MUL_A_W-1:0] a_reg;
    logic [MUL_A_W-1:0] hi_reg;
    logic [MUL_B_W-1:0] lo_reg;
    logic [MUL_A_W:0]   sum_next;

    // partial product enters at the top, the word shifts right one bit
    assign sum_next = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= mcand;
            hi_reg  <= '0;
            lo_reg  <= mplier;
            cnt_reg <= CNT_W'(MUL_B_W);
        end else if (busy_reg) begin
            hi_reg  <= sum_next[MUL_A_W:1];
            lo_reg  <= {sum_next[0], lo_reg[MUL_B_W-1:1]};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

[rtl/opi_div_serial.sv]
// restoring divider by one million with round-half-up, one quotient bit per cycle
module opi_div_serial
    import opi_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_N_W-1:0] mag,
    output logic               done,
    output logic [DIV_Q_W-1:0] quot
);

    localparam int CNT_W = $clog2(DIV_Q_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_R_W-1:0] r_reg;
    logic [DIV_Q_W-1:0] q_reg;
    logic [DIV_N_W-1:0] num;
    logic [DIV_R_W:0]   trial;
    logic               fits;

    // the upper part of the numerator is known to be below the divisor
    assign num   = mag + DIV_N_W'(US_HALF);
    assign trial = {r_reg, q_reg[DIV_Q_W-1]};
    assign fits  = trial >= {1'b0, US_PER_S};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            r_reg   <= num[DIV_N_W-1:DIV_Q_W];
            q_reg   <= num[DIV_Q_W-1:0];
            cnt_reg <= CNT_W'(DIV_Q_W);
        end else if (busy_reg) begin
            r_reg   <= fits ? DIV_R_W'(trial - {1'b0, US_PER_S}) : trial[DIV_R_W-1:0];
            q_reg   <= {q_reg[DIV_Q_W-2:0], fits};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

[rtl/opi_checker.sv]
// port-level checks of the odometry pose integrator, bound to the top level
module opi_checker
    import opi_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // ticks taken in and not yet handed out
    always_comb begin
        pending_next = pending_reg;
        if (in_xfer && !out_xfer) begin
            pending_next = pending_reg + 2'd1;
        end else if (out_xfer && !in_xfer) begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 2'd0)
        else $error("result without a pending tick");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg == 2'd2 |-> !s_tready)
        else $error("third tick taken while two are pending");

endmodule

bind odometry_pose_integrator_top opi_checker u_opi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/odometry_pose_integrator_top_tb.sv]
// self-checking testbench of the odometry pose integrator: directed table, then random ticks
`timescale 1ns / 100ps

module odometry_pose_integrator_top_tb
    import opi_pkg::*;
();

    localparam int N_ROT          = 16;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 150;
    localparam int N_TABLE        = 25;
    localparam int N_RANDOM       = 1150;

    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_TWO_PI  = 64'sd6746518852;
    localparam longint ROT_GAIN    = 64'sd652032874;
    localparam longint USEC        = 64'sd1000000;
    localparam longint TURN_LIMIT  = 25763;
    localparam longint TURN_STEP   = 25736;
    localparam longint HEAD_TOP    = 65535;
    localparam longint HEAD_BOTTOM = -65536;
    localparam longint ATAN_TAB [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };

    typedef struct {
        bit load;
        int nx;
        int ny;
        int nh;
        int lin;
        int ang;
        int dt;
        bit known;
        int ex;
        int ey;
        int eh;
    } tick_t;

    typedef struct {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [HEAD_W-1:0] h;
    } pose_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // new_x, new_y, new_heading, linear_speed, angular_speed, elapsed_us, zero pad
    logic [S_TDATA_W-1:0] s_tdata;
    // load_pose
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // pos_x, pos_y, heading, zero pad
    logic [M_TDATA_W-1:0] m_tdata;

    pose_t  expected_poses[$];
    tick_t  tick_table[N_TABLE];
    longint cur_x, cur_y, cur_h;
    int     errors;
    int     quiet_cycles;
    int     src_idle;
    int     dst_idle;

    odometry_pose_integrator_top #(
        .CORDIC_STEPS(N_ROT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // cos and sin of a q4.12 heading, q1.30, by rotation-mode cordic
    function automatic void heading_sincos(input longint th, output longint cs,
                                           output longint sn);
        longint a, x, y, z, xs, ys;
        bit     flip;
        a = th * 262144;
        x = ROT_GAIN;
        y = 0;
        flip = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (a > Q30_PI) a -= Q30_TWO_PI;
            else if (a <= -Q30_PI) a += Q30_TWO_PI;
        end
        // fold into the right half plane, which negates both outputs
        if (a > Q30_HALF_PI) begin
            a -= Q30_PI;
            flip = 1'b1;
        end else if (a < -Q30_HALF_PI) begin
            a += Q30_PI;
            flip = 1'b1;
        end
        z = a;
        for (int i = 0; i < N_ROT && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= ATAN_TAB[i];
            end else begin
                x += ys;
                y -= xs;
                z += ATAN_TAB[i];
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    // pose after one tick, updating the tracked pose
    function automatic pose_t advance_pose(input tick_t t);
        longint v, w, dt, cs, sn, vx, vy, th;
        pose_t  p;
        if (t.load) begin
            cur_x = longint'($signed(t.nx[31:0]));
            cur_y = longint'($signed(t.ny[31:0]));
            cur_h = longint'($signed(t.nh[15:0]));
        end else begin
            v  = longint'($signed(t.lin[15:0]));
            w  = longint'($signed(t.ang[15:0]));
            dt = longint'(t.dt[19:0]);
            if (v != 0 || w != 0) begin
                heading_sincos(cur_h, cs, sn);
                vx = round_div(v * cs, 64'sd4194304);
                vy = round_div(v * sn, 64'sd4194304);
                cur_x = clamp(cur_x + round_div(vx * dt, USEC), -64'sd2147483648,
                              64'sd2147483647);
                cur_y = clamp(cur_y + round_div(vy * dt, USEC), -64'sd2147483648,
                              64'sd2147483647);
                th = cur_h + round_div(w * dt, USEC);
                if (th > TURN_LIMIT) th -= TURN_STEP;
                else if (th < -TURN_LIMIT) th += TURN_STEP;
                cur_h = clamp(th, HEAD_BOTTOM, HEAD_TOP);
            end
        end
        p.x = cur_x[31:0];
        p.y = cur_y[31:0];
        p.h = cur_h[16:0];
        return p;
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        int    r;
        r = $urandom_range(0, 99);
        t.known = 1'b0;
        t.ex = 0;
        t.ey = 0;
        t.eh = 0;
        t.load = (r < 6);
        if ($urandom_range(0, 1)) begin
            t.nx = int'($urandom());
            t.ny = int'($urandom());
        end else begin
            t.nx = int'($urandom_range(0, 2097151)) - 1048576;
            t.ny = int'($urandom_range(0, 2097151)) - 1048576;
        end
        t.nh = int'($urandom_range(0, 51528)) - 25764;
        if ($urandom_range(0, 1)) begin
            t.lin = int'($urandom_range(0, 65535)) - 32768;
            t.ang = int'($urandom_range(0, 65535)) - 32768;
        end else begin
            t.lin = int'($urandom_range(0, 1023)) - 512;
            t.ang = int'($urandom_range(0, 8191)) - 4096;
        end
        t.dt = $urandom_range(0, 1) ? int'($urandom_range(0, 999999))
                                    : int'($urandom_range(0, 20000));
        // ticks with the robot standing still
        if (r >= 6 && r < 11) begin
            t.lin = 0;
            t.ang = 0;
        end
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        pose_t p;
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= t.load;
        s_tdata  <= {4'b0, t.dt[19:0], t.ang[15:0], t.lin[15:0], t.nh[15:0],
                     t.ny[31:0], t.nx[31:0]};
        do @(posedge aclk); while (!s_tready);
        p = advance_pose(t);
        if (t.known) begin
            p.x = t.ex[31:0];
            p.y = t.ey[31:0];
            p.h = t.eh[16:0];
        end
        expected_poses.push_back(p);
    endtask

    // hold the input side until every outstanding pose has come back
    task automatic drain_poses();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge aclk);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) send_tick(random_tick());
    endtask

    // receiver side: random back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= dst_idle);
    end

    always @(posedge aclk) begin
        pose_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("odometry_pose_integrator_top_tb failed");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_poses.size() == 0) begin
                report_mismatch("results pending", 1, 0);
            end else begin
                want = expected_poses.pop_front();
                if (m_tdata[31:0] !== want.x)
                    report_mismatch("pos_x", $signed(m_tdata[31:0]), $signed(want.x));
                if (m_tdata[63:32] !== want.y)
                    report_mismatch("pos_y", $signed(m_tdata[63:32]), $signed(want.y));
                if (m_tdata[80:64] !== want.h)
                    report_mismatch("heading", $signed(m_tdata[80:64]), $signed(want.h));
            end
        end
    end

    initial begin
        // load, x, y, heading, v, w, dt, known, x, y, heading
        tick_table[0]  = '{0, 0, 0, 0, 0, 0, 999999, 1, 0, 0, 0};
        tick_table[1]  = '{0, 0, 0, 0, 256, 0, 0, 1, 0, 0, 0};
        tick_table[2]  = '{1, 32'h7FFFFFFF, 32'h7FFFFFFF, 25764, -32768, 32767, 999999,
                           1, 32'h7FFFFFFF, 32'h7FFFFFFF, 25764};
        tick_table[3]  = '{0, 0, 0, 0, 32767, 0, 999999, 0, 0, 0, 0};
        tick_table[4]  = '{1, 32'h80000000, 32'h80000000, -25764, 5, 5, 5,
                           1, 32'h80000000, 32'h80000000, -25764};
        tick_table[5]  = '{0, 0, 0, 0, -32768, -32768, 999999, 0, 0, 0, 0};
        tick_table[6]  = '{1, 0, 0, 25764, 0, 0, 0, 1, 0, 0, 25764};
        // heading wrap with no elapsed time
        tick_table[7]  = '{0, 0, 0, 0, 1, 0, 0, 1, 0, 0, 28};
        tick_table[8]  = '{1, 0, 0, -25764, 0, 0, 0, 1, 0, 0, -25764};
        tick_table[9]  = '{0, 0, 0, 0, 0, 1, 0, 1, 0, 0, -28};
        tick_table[10] = '{1, 0, 0, 25763, 0, 0, 0, 1, 0, 0, 25763};
        tick_table[11] = '{0, 0, 0, 0, 0, 1, 0, 1, 0, 0, 25763};
        // full turn rate until the heading saturates
        for (int i = 12; i < 18; i++) tick_table[i] = '{0, 0, 0, 0, 0, 32767, 999999,
                                                        0, 0, 0, 0};
        tick_table[18] = '{0, 0, 0, 0, 0, -32768, 999999, 0, 0, 0, 0};
        tick_table[19] = '{1, 0, 0, 12868, 0, 0, 0, 1, 0, 0, 12868};
        tick_table[20] = '{0, 0, 0, 0, 32767, -32768, 500000, 0, 0, 0, 0};
        tick_table[21] = '{1, 0, 0, -12868, 0, 0, 0, 1, 0, 0, -12868};
        tick_table[22] = '{0, 0, 0, 0, -32768, 32767, 1, 0, 0, 0, 0};
        tick_table[23] = '{1, 0, 0, 6434, 0, 0, 0, 1, 0, 0, 6434};
        tick_table[24] = '{0, 0, 0, 0, 256, 0, 999999, 0, 0, 0, 0};

        errors       = 0;
        quiet_cycles = 0;
        cur_x        = 0;
        cur_y        = 0;
        cur_h        = 0;
        src_idle     = 13;
        dst_idle     = 50;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        m_tready     = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_TABLE; i++) send_tick(tick_table[i]);
        run_random(N_RANDOM / 3);
        drain_poses();

        src_idle = 50;
        dst_idle = 13;
        run_random(N_RANDOM / 3);
        drain_poses();

        src_idle = 0;
        dst_idle = 0;
        run_random(N_RANDOM - 2 * (N_RANDOM / 3));
        drain_poses();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("odometry_pose_integrator_top_tb passed");
        end else begin
            $display("odometry_pose_integrator_top_tb failed");
        end
        $finish;
    end

endmodule
